// ===== rtl/core/rcr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the range capacity reservation block: field widths, result status codes,
// and the command and status structs that join the controller and the datapath.
// It depends on nothing.
package rcr_pkg;

   localparam int DATA_W   = 32;
   localparam int AMT_W    = 31;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 20;

   typedef logic [STATUS_W-1:0] status_code_type;
   localparam status_code_type STATUS_LOAD   = 2'd0;
   localparam status_code_type STATUS_GRANT  = 2'd1;
   localparam status_code_type STATUS_REJECT = 2'd2;
   localparam status_code_type STATUS_REFUSE = 2'd3;

   // Node index base selection.
   typedef logic [1:0] base_sel_type;
   localparam base_sel_type BASE_S = 2'd0;
   localparam base_sel_type BASE_T = 2'd1;
   localparam base_sel_type BASE_I = 2'd2;

   // Read address selection, relative to the selected base index.
   typedef logic [2:0] rd_sel_type;
   localparam rd_sel_type RD_BASE = 3'd0;
   localparam rd_sel_type RD_SIB  = 3'd1;
   localparam rd_sel_type RD_PAR  = 3'd2;
   localparam rd_sel_type RD_LCH  = 3'd3;
   localparam rd_sel_type RD_RCH  = 3'd4;

   // Which operand register captures the memory read data.
   typedef logic [2:0] cap_sel_type;
   localparam cap_sel_type CAP_NONE = 3'd0;
   localparam cap_sel_type CAP_A    = 3'd1;
   localparam cap_sel_type CAP_B    = 3'd2;
   localparam cap_sel_type CAP_P    = 3'd3;
   localparam cap_sel_type CAP_Q    = 3'd4;

   // Memory write operations.
   typedef logic [3:0] wr_sel_type;
   localparam wr_sel_type WR_NONE     = 4'd0;
   localparam wr_sel_type WR_LEAF     = 4'd1;
   localparam wr_sel_type WR_CLR      = 4'd2;
   localparam wr_sel_type WR_BASE_M   = 4'd3;
   localparam wr_sel_type WR_LCH_A_M  = 4'd4;
   localparam wr_sel_type WR_RCH_B_M  = 4'd5;
   localparam wr_sel_type WR_BASE_A_M = 4'd6;
   localparam wr_sel_type WR_SIB_B_M  = 4'd7;
   localparam wr_sel_type WR_PAR_P_M  = 4'd8;
   localparam wr_sel_type WR_SIB_SUB  = 4'd9;

   // Register updates in the datapath.
   typedef logic [3:0] act_type;
   localparam act_type ACT_NONE        = 4'd0;
   localparam act_type ACT_ACCEPT      = 4'd1;
   localparam act_type ACT_I_INC       = 4'd2;
   localparam act_type ACT_I_TOP       = 4'd3;
   localparam act_type ACT_I_DEC       = 4'd4;
   localparam act_type ACT_QSTEP       = 4'd5;
   localparam act_type ACT_QEND        = 4'd6;
   localparam act_type ACT_SHR_S       = 4'd7;
   localparam act_type ACT_ANS_ADD     = 4'd8;
   localparam act_type ACT_SUB_INIT    = 4'd9;
   localparam act_type ACT_SHR_ST      = 4'd10;
   localparam act_type ACT_RESP_LOAD   = 4'd11;
   localparam act_type ACT_RESP_REFUSE = 4'd12;
   localparam act_type ACT_RESP_REJECT = 4'd13;
   localparam act_type ACT_RESP_GRANT  = 4'd14;

   typedef struct packed {
      base_sel_type base;
      rd_sel_type   rd;
      cap_sel_type  cap;
      wr_sel_type   wr;
      act_type      act;
   } cmd_type;

   typedef struct packed {
      logic command;
      logic load_last;
      logic failed;
      logic s_eq_t;
      logic st_sib;
      logic s_even;
      logic t_odd;
      logic s_gt1;
      logic grant;
      logic i_one;
      logic i_last;
   } status_type;

endpackage

// ===== rtl/core/range_capacity_reservation.sv =====
`timescale 1ns / 1ps
// Top level of the range capacity reservation block: a segment tree of slot capacities
// with range minimum and range subtract. It depends on rcr_pkg, rcr_ctrl and rcr_datapath.
//
// Usage. An item is transferred at a rising edge where start is high and busy is low.
// A load item (req_command low) writes one slot capacity; a load with req_load_last
// high also builds the tree over all TREE_LEAVES leaves. A reserve item (req_command
// high) takes the minimum capacity over the slot range and, when that minimum covers
// req_amount, subtracts req_amount over the whole range. The first reserve that does
// not fit is rejected and every later reserve is refused.
// Every item gives exactly one result, shown for one cycle with rsp_valid high. The
// receiver cannot stall; each result is taken in the cycle it is shown. Busy falls in
// that same cycle, so the next item can be transferred while the result is on the ports.
// Sequence. A load with build then walks the internal nodes from the top index down.
// A refused reserve is answered from the dispatch state. A reserve runs the query walk
// up both boundary paths and then on the way to the root, then the update walk with up to
// two sibling adjusts and two pair lifts per level, each a read-modify-write through the
// single read port and single write port of the node memory.
// Reset. After reset the node memory is cleared one node per cycle, with busy high until
// every node is clear; the request counter and the failure flag start at zero.
module range_capacity_reservation #(
   parameter int TREE_LEAVES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [rcr_pkg::SLOT_W-1:0]   req_first_slot,
   input  logic [rcr_pkg::SLOT_W-1:0]   req_last_slot,
   input  logic [rcr_pkg::AMT_W-1:0]    req_amount,
   input  logic                         req_load_last,
   output logic                         rsp_valid,
   output logic [rcr_pkg::STATUS_W-1:0] rsp_status,
   output logic [rcr_pkg::COUNT_W-1:0]  rsp_request_number,
   output logic [rcr_pkg::AMT_W-1:0]    rsp_range_minimum
);
   import rcr_pkg::*;

   cmd_type    cmd;
   status_type st;

   // The controller sequences every memory step; the datapath owns the node memory and all data registers.
   rcr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .st   (st),
      .cmd  (cmd)
   );

   // Request fields are sampled by the datapath in the transfer cycle.
   rcr_datapath #(
      .TREE_LEAVES(TREE_LEAVES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_command       (req_command),
      .req_first_slot    (req_first_slot),
      .req_last_slot     (req_last_slot),
      .req_amount        (req_amount),
      .req_load_last     (req_load_last),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_request_number(rsp_request_number),
      .rsp_range_minimum (rsp_range_minimum)
   );

endmodule

// ===== rtl/core/rcr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module rcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rcr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the range capacity reservation block: node memory, walk indices,
// operand and sum registers, request counter, failure flag and result registers.
// It depends on rcr_pkg and rcr_ram.
module rcr_datapath #(
   parameter int TREE_LEAVES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rcr_pkg::cmd_type                 cmd,
   output rcr_pkg::status_type              st,
   input  logic                             req_command,
   input  logic [rcr_pkg::SLOT_W-1:0]       req_first_slot,
   input  logic [rcr_pkg::SLOT_W-1:0]       req_last_slot,
   input  logic [rcr_pkg::AMT_W-1:0]        req_amount,
   input  logic                             req_load_last,
   output logic                             rsp_valid,
   output logic [rcr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rcr_pkg::COUNT_W-1:0]      rsp_request_number,
   output logic [rcr_pkg::AMT_W-1:0]        rsp_range_minimum
);
   import rcr_pkg::*;

   localparam int IW = $clog2(TREE_LEAVES) + 1;
   localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;
   localparam int SW = DATA_W + IW;
   localparam logic [CW-1:0] SLOT_MAX = CW'(TREE_LEAVES - 2);
   localparam logic [IW-1:0] I_TOP    = IW'(TREE_LEAVES - 1);

   logic                    command_ff, command_in;
   logic                    load_last_ff, load_last_in;
   logic [SLOT_W-1:0]       first_ff, first_in;
   logic [AMT_W-1:0]        amount_ff, amount_in;
   logic [IW-2:0]           lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0]           s_ff, s_in, t_ff, t_in, i_ff, i_in;
   logic signed [DATA_W-1:0] a_ff, a_in, b_ff, b_in, p_ff, p_in, q_ff, q_in;
   logic signed [SW-1:0]    left_ff, left_in, right_ff, right_in, ans_ff, ans_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    failed_ff, failed_in;
   logic                    valid_ff, valid_in;
   status_code_type         status_ff, status_in;
   logic [COUNT_W-1:0]      number_ff, number_in;
   logic [AMT_W-1:0]        minimum_ff, minimum_in;

   logic [CW-1:0]           first_ext, last_ext, first_c, last_c, stored_first;
   logic                    leaf_ok;
   logic [IW-1:0]           base, lch, rch, rd_addr, wr_addr;
   logic [DATA_W-1:0]       wr_data, rd_data;
   logic                    wr_en;
   logic signed [DATA_W-1:0] m;
   logic signed [SW-1:0]    lsum, rsum;

   rcr_ram #(
      .WIDTH(DATA_W),
      .DEPTH(2 * TREE_LEAVES)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Slot clamping into the usable range, and the range check on the stored load slot.
   always_comb begin
      first_ext = CW'(req_first_slot);
      last_ext  = CW'(req_last_slot);
      first_c = (first_ext == '0) ? CW'(1) : ((first_ext > SLOT_MAX) ? SLOT_MAX : first_ext);
      last_c  = (last_ext == '0) ? CW'(1) : ((last_ext > SLOT_MAX) ? SLOT_MAX : last_ext);
      stored_first = CW'(first_ff);
      leaf_ok = (stored_first != '0) && (stored_first <= SLOT_MAX);
   end

   always_comb begin
      case (cmd.base)
         BASE_S:  base = s_ff;
         BASE_T:  base = t_ff;
         BASE_I:  base = i_ff;
         default: base = s_ff;
      endcase
      lch = {base[IW-2:0], 1'b0};
      rch = {base[IW-2:0], 1'b1};
      case (cmd.rd)
         RD_BASE: rd_addr = base;
         RD_SIB:  rd_addr = base ^ IW'(1);
         RD_PAR:  rd_addr = base >> 1;
         RD_LCH:  rd_addr = lch;
         RD_RCH:  rd_addr = rch;
         default: rd_addr = base;
      endcase
   end

   assign m = (a_ff < b_ff) ? a_ff : b_ff;

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = base;
      wr_data = '0;
      case (cmd.wr)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_LEAF: begin
            wr_en   = leaf_ok;
            wr_addr = {1'b1, stored_first[IW-2:0]};
            wr_data = DATA_W'(amount_ff);
         end
         WR_CLR: begin
            wr_addr = i_ff;
         end
         WR_BASE_M: begin
            wr_data = m;
         end
         WR_LCH_A_M: begin
            wr_addr = lch;
            wr_data = a_ff - m;
         end
         WR_RCH_B_M: begin
            wr_addr = rch;
            wr_data = b_ff - m;
         end
         WR_BASE_A_M: begin
            wr_data = a_ff - m;
         end
         WR_SIB_B_M: begin
            wr_addr = base ^ IW'(1);
            wr_data = b_ff - m;
         end
         WR_PAR_P_M: begin
            wr_addr = base >> 1;
            wr_data = p_ff + m;
         end
         WR_SIB_SUB: begin
            wr_addr = base ^ IW'(1);
            wr_data = b_ff - DATA_W'(amount_ff);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      q_in = q_ff;
      case (cmd.cap)
         CAP_A:   a_in = rd_data;
         CAP_B:   b_in = rd_data;
         CAP_P:   p_in = rd_data;
         CAP_Q:   q_in = rd_data;
         default: a_in = a_ff;
      endcase
   end

   always_comb begin
      command_in   = command_ff;
      load_last_in = load_last_ff;
      first_in     = first_ff;
      amount_in    = amount_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      i_in         = i_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      ans_in       = ans_ff;
      count_in     = count_ff;
      failed_in    = failed_ff;
      valid_in     = 1'b0;
      status_in    = status_ff;
      number_in    = number_ff;
      minimum_in   = minimum_ff;
      lsum = left_ff + SW'(a_ff);
      rsum = right_ff + SW'(p_ff);
      case (cmd.act)
         ACT_ACCEPT: begin
            command_in   = req_command;
            load_last_in = req_load_last;
            first_in     = req_first_slot;
            amount_in    = req_amount;
            if (first_c > last_c) begin
               lo_in = last_c[IW-2:0];
               hi_in = first_c[IW-2:0];
            end else begin
               lo_in = first_c[IW-2:0];
               hi_in = last_c[IW-2:0];
            end
            s_in     = {1'b1, lo_in};
            t_in     = {1'b1, hi_in};
            left_in  = '0;
            right_in = '0;
            if (req_command && (count_ff != '1)) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_I_INC: i_in = i_ff + IW'(1);
         ACT_I_TOP: i_in = I_TOP;
         ACT_I_DEC: i_in = i_ff - IW'(1);
         ACT_QSTEP: begin
            left_in  = (!s_ff[0] && (SW'(b_ff) < lsum)) ? SW'(b_ff) : lsum;
            right_in = (t_ff[0] && (SW'(q_ff) < rsum)) ? SW'(q_ff) : rsum;
            s_in     = s_ff >> 1;
            t_in     = t_ff >> 1;
         end
         ACT_QEND: ans_in = (lsum < rsum) ? lsum : rsum;
         ACT_SHR_S: s_in = s_ff >> 1;
         ACT_ANS_ADD: ans_in = ans_ff + SW'(signed'(rd_data));
         ACT_SUB_INIT: begin
            s_in = {1'b1, lo_ff} - IW'(1);
            t_in = {1'b1, hi_ff} + IW'(1);
         end
         ACT_SHR_ST: begin
            s_in = s_ff >> 1;
            t_in = t_ff >> 1;
         end
         ACT_RESP_LOAD: begin
            valid_in   = 1'b1;
            status_in  = STATUS_LOAD;
            number_in  = count_ff;
            minimum_in = '0;
         end
         ACT_RESP_REFUSE: begin
            valid_in   = 1'b1;
            status_in  = STATUS_REFUSE;
            number_in  = count_ff;
            minimum_in = '0;
         end
         ACT_RESP_REJECT: begin
            valid_in   = 1'b1;
            failed_in  = 1'b1;
            status_in  = STATUS_REJECT;
            number_in  = count_ff;
            minimum_in = ans_ff[AMT_W-1:0];
         end
         ACT_RESP_GRANT: begin
            valid_in   = 1'b1;
            status_in  = STATUS_GRANT;
            number_in  = count_ff;
            minimum_in = ans_ff[AMT_W-1:0];
         end
         default: valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff      <= '0;
         count_ff  <= '0;
         failed_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         i_ff      <= i_in;
         count_ff  <= count_in;
         failed_ff <= failed_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff   <= command_in;
      load_last_ff <= load_last_in;
      first_ff     <= first_in;
      amount_ff    <= amount_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      ans_ff       <= ans_in;
      status_ff    <= status_in;
      number_ff    <= number_in;
      minimum_ff   <= minimum_in;
   end

   always_comb begin
      st.command   = command_ff;
      st.load_last = load_last_ff;
      st.failed    = failed_ff;
      st.s_eq_t    = (s_ff == t_ff);
      st.st_sib    = ((s_ff ^ t_ff) == IW'(1));
      st.s_even    = !s_ff[0];
      st.t_odd     = t_ff[0];
      st.s_gt1     = (s_ff > IW'(1));
      // The minimum can be negative, so the amount is compared as a signed value.
      st.grant     = (ans_ff >= $signed(SW'(amount_ff)));
      st.i_one     = (i_ff == IW'(1));
      st.i_last    = (i_ff == '1);
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_request_number = number_ff;
   assign rsp_range_minimum  = minimum_ff;

endmodule

// ===== rtl/core/rcr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the range capacity reservation block: the state machine that sequences
// the memory clear, tree build, range query and range update through the datapath.
// It depends on rcr_pkg.
module rcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rcr_pkg::status_type st,
   output rcr_pkg::cmd_type    cmd
);
   import rcr_pkg::*;

   localparam logic [5:0] S_CLEAR = 6'd0,  S_IDLE = 6'd1,  S_DISP = 6'd2,  S_LDONE = 6'd3;
   localparam logic [5:0] S_BR0 = 6'd4,  S_BR1 = 6'd5,  S_BC = 6'd6;
   localparam logic [5:0] S_BW0 = 6'd7,  S_BW1 = 6'd8,  S_BW2 = 6'd9;
   localparam logic [5:0] S_Q0 = 6'd10,  S_QL0 = 6'd11, S_QL1 = 6'd12, S_QL2 = 6'd13;
   localparam logic [5:0] S_QL3 = 6'd14, S_QL4 = 6'd15, S_QL5 = 6'd16;
   localparam logic [5:0] S_QE0 = 6'd17, S_QE1 = 6'd18, S_QE2 = 6'd19, S_QE3 = 6'd20;
   localparam logic [5:0] S_QP0 = 6'd21, S_QP1 = 6'd22, S_QP2 = 6'd23, S_DEC = 6'd24;
   localparam logic [5:0] S_U0 = 6'd25,  S_U1 = 6'd26,  S_U2 = 6'd27,  S_U3 = 6'd28;
   localparam logic [5:0] S_U4 = 6'd29,  S_U5 = 6'd30,  S_U6 = 6'd31;
   localparam logic [5:0] S_LA0 = 6'd32, S_LA1 = 6'd33, S_LA2 = 6'd34, S_LA3 = 6'd35;
   localparam logic [5:0] S_LA4 = 6'd36, S_LA5 = 6'd37, S_LA6 = 6'd38, S_UF0 = 6'd39;

   localparam logic [1:0] PH_S = 2'd0, PH_T = 2'd1, PH_F = 2'd2;

   logic [5:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   base_sel_type lift_base;

   assign lift_base = (phase_ff == PH_T) ? BASE_T : BASE_S;
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd.base = BASE_S;
      cmd.rd   = RD_BASE;
      cmd.cap  = CAP_NONE;
      cmd.wr   = WR_NONE;
      cmd.act  = ACT_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr  = WR_CLR;
            cmd.act = ACT_I_INC;
            if (st.i_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.act  = ACT_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!st.command) begin
               cmd.wr   = WR_LEAF;
               cmd.act  = ACT_I_TOP;
               state_in = st.load_last ? S_BR0 : S_LDONE;
            end else if (st.failed) begin
               cmd.act  = ACT_RESP_REFUSE;
               state_in = S_IDLE;
            end else begin
               state_in = S_Q0;
            end
         end
         S_LDONE: begin
            cmd.act  = ACT_RESP_LOAD;
            state_in = S_IDLE;
         end
         // Tree build, one internal node per pass from the top index downward.
         S_BR0: begin
            cmd.base = BASE_I;
            cmd.rd   = RD_LCH;
            state_in = S_BR1;
         end
         S_BR1: begin
            cmd.base = BASE_I;
            cmd.rd   = RD_RCH;
            cmd.cap  = CAP_A;
            state_in = S_BC;
         end
         S_BC: begin
            cmd.cap  = CAP_B;
            state_in = S_BW0;
         end
         S_BW0: begin
            cmd.base = BASE_I;
            cmd.wr   = WR_BASE_M;
            state_in = S_BW1;
         end
         S_BW1: begin
            cmd.base = BASE_I;
            cmd.wr   = WR_LCH_A_M;
            state_in = S_BW2;
         end
         S_BW2: begin
            cmd.base = BASE_I;
            cmd.wr   = WR_RCH_B_M;
            cmd.act  = ACT_I_DEC;
            state_in = st.i_one ? S_LDONE : S_BR0;
         end
         // Range minimum: walk both boundary paths upward.
         S_Q0: begin
            state_in = (st.s_eq_t || st.st_sib) ? S_QE0 : S_QL0;
         end
         S_QL0: begin
            cmd.rd   = RD_BASE;
            state_in = S_QL1;
         end
         S_QL1: begin
            cmd.rd   = RD_SIB;
            cmd.cap  = CAP_A;
            state_in = S_QL2;
         end
         S_QL2: begin
            cmd.base = BASE_T;
            cmd.rd   = RD_BASE;
            cmd.cap  = CAP_B;
            state_in = S_QL3;
         end
         S_QL3: begin
            cmd.base = BASE_T;
            cmd.rd   = RD_SIB;
            cmd.cap  = CAP_P;
            state_in = S_QL4;
         end
         S_QL4: begin
            cmd.cap  = CAP_Q;
            state_in = S_QL5;
         end
         S_QL5: begin
            cmd.act  = ACT_QSTEP;
            state_in = S_Q0;
         end
         S_QE0: begin
            cmd.rd   = RD_BASE;
            state_in = S_QE1;
         end
         S_QE1: begin
            cmd.base = BASE_T;
            cmd.rd   = RD_BASE;
            cmd.cap  = CAP_A;
            state_in = S_QE2;
         end
         S_QE2: begin
            cmd.cap  = CAP_P;
            state_in = S_QE3;
         end
         S_QE3: begin
            cmd.act  = ACT_QEND;
            state_in = S_QP0;
         end
         S_QP0: begin
            if (st.s_gt1) begin
               cmd.act  = ACT_SHR_S;
               state_in = S_QP1;
            end else begin
               state_in = S_DEC;
            end
         end
         S_QP1: begin
            cmd.rd   = RD_BASE;
            state_in = S_QP2;
         end
         S_QP2: begin
            cmd.act  = ACT_ANS_ADD;
            state_in = S_QP0;
         end
         S_DEC: begin
            if (st.grant) begin
               cmd.act  = ACT_SUB_INIT;
               state_in = S_U0;
            end else begin
               cmd.act  = ACT_RESP_REJECT;
               state_in = S_IDLE;
            end
         end
         // Range update between the two open boundaries.
         S_U0: begin
            state_in = st.st_sib ? S_UF0 : S_U1;
         end
         S_U1: begin
            if (st.s_even) begin
               cmd.rd   = RD_SIB;
               state_in = S_U2;
            end else begin
               state_in = S_U4;
            end
         end
         S_U2: begin
            cmd.cap  = CAP_B;
            state_in = S_U3;
         end
         S_U3: begin
            cmd.wr   = WR_SIB_SUB;
            state_in = S_U4;
         end
         S_U4: begin
            if (st.t_odd) begin
               cmd.base = BASE_T;
               cmd.rd   = RD_SIB;
               state_in = S_U5;
            end else begin
               phase_in = PH_S;
               state_in = S_LA0;
            end
         end
         S_U5: begin
            cmd.cap  = CAP_B;
            state_in = S_U6;
         end
         S_U6: begin
            cmd.base = BASE_T;
            cmd.wr   = WR_SIB_SUB;
            phase_in = PH_S;
            state_in = S_LA0;
         end
         // Pair lift: move the common minimum of a node and its sibling into the parent.
         S_LA0: begin
            cmd.base = lift_base;
            cmd.rd   = RD_BASE;
            state_in = S_LA1;
         end
         S_LA1: begin
            cmd.base = lift_base;
            cmd.rd   = RD_SIB;
            cmd.cap  = CAP_A;
            state_in = S_LA2;
         end
         S_LA2: begin
            cmd.base = lift_base;
            cmd.rd   = RD_PAR;
            cmd.cap  = CAP_B;
            state_in = S_LA3;
         end
         S_LA3: begin
            cmd.cap  = CAP_P;
            state_in = S_LA4;
         end
         S_LA4: begin
            cmd.base = lift_base;
            cmd.wr   = WR_BASE_A_M;
            state_in = S_LA5;
         end
         S_LA5: begin
            cmd.base = lift_base;
            cmd.wr   = WR_SIB_B_M;
            state_in = S_LA6;
         end
         S_LA6: begin
            cmd.base = lift_base;
            cmd.wr   = WR_PAR_P_M;
            case (phase_ff)
               PH_S: begin
                  phase_in = PH_T;
                  state_in = S_LA0;
               end
               PH_T: begin
                  cmd.act  = ACT_SHR_ST;
                  state_in = S_U0;
               end
               default: begin
                  cmd.act  = ACT_SHR_S;
                  state_in = S_UF0;
               end
            endcase
         end
         S_UF0: begin
            if (st.s_gt1) begin
               phase_in = PH_F;
               state_in = S_LA0;
            end else begin
               cmd.act  = ACT_RESP_GRANT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= PH_S;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for range_capacity_reservation: directed and random load and reserve
// transfers, checked against a segment tree predictor kept inside this file.
// It depends on rcr_pkg and the range_capacity_reservation RTL.
module testbench;
   import rcr_pkg::*;

   localparam int LEAVES   = 1024;
   localparam int NODES    = 2 * LEAVES;
   localparam int SLOT_TOP = LEAVES - 2;
   localparam int REGION   = 32;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_RESERVE = 1'b1;

   typedef struct packed {
      status_code_type        status;
      logic [COUNT_W-1:0]     number;
      logic [AMT_W-1:0]       minimum;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_command = 1'b0;
   logic [SLOT_W-1:0]     req_first_slot = '0;
   logic [SLOT_W-1:0]     req_last_slot = '0;
   logic [AMT_W-1:0]      req_amount = '0;
   logic                  req_load_last = 1'b0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_request_number;
   logic [AMT_W-1:0]      rsp_range_minimum;

   // Predicted contents of the node memory, the request count and the failure flag.
   logic [31:0]           cap_tree [0:NODES-1];
   logic [COUNT_W-1:0]    request_count;
   logic                  refusing;
   outcome_type           outcome_q [$];
   int                    errors = 0;
   int                    gap_pct = 0;
   int                    region_base = 1;

   always #6 clock = ~clock;

   range_capacity_reservation #(.TREE_LEAVES(LEAVES)) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_first_slot     (req_first_slot),
      .req_last_slot      (req_last_slot),
      .req_amount         (req_amount),
      .req_load_last      (req_load_last),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_request_number (rsp_request_number),
      .rsp_range_minimum  (rsp_range_minimum)
   );

   // Nodes are 32-bit two's complement; all sums are done in 64 bits so they never wrap.
   function automatic longint cap_get(int unsigned i);
      return longint'($signed(cap_tree[i % NODES]));
   endfunction

   function automatic void cap_set(int unsigned i, longint x);
      cap_tree[i % NODES] = x[31:0];
   endfunction

   function automatic longint min_of(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   // Move the common minimum of a node and its sibling up into their parent.
   function automatic void pair_lift(int unsigned i);
      longint m;
      m = min_of(cap_get(i), cap_get(i ^ 1));
      cap_set(i, cap_get(i) - m);
      cap_set(i ^ 1, cap_get(i ^ 1) - m);
      cap_set(i >> 1, cap_get(i >> 1) + m);
   endfunction

   // The build treats every leaf as an absolute capacity and rewrites all inner nodes.
   function automatic void tree_build();
      longint m;
      for (int unsigned i = LEAVES - 1; i >= 1; i--) begin
         m = min_of(cap_get(2 * i), cap_get(2 * i + 1));
         cap_set(i, m);
         cap_set(2 * i, cap_get(2 * i) - m);
         cap_set(2 * i + 1, cap_get(2 * i + 1) - m);
      end
   endfunction

   function automatic longint span_min(int unsigned lo, int unsigned hi);
      int unsigned s, t;
      longint left, right, ans;
      s = lo + LEAVES;
      t = hi + LEAVES;
      left = 0;
      right = 0;
      if (s != t) begin
         while ((s ^ t ^ 1) != 0) begin
            left += cap_get(s);
            right += cap_get(t);
            if ((s & 1) == 0) left = min_of(left, cap_get(s ^ 1));
            if ((t & 1) != 0) right = min_of(right, cap_get(t ^ 1));
            s >>= 1;
            t >>= 1;
         end
      end
      ans = min_of(left + cap_get(s), right + cap_get(t));
      while (s > 1) begin
         s >>= 1;
         ans += cap_get(s);
      end
      return ans;
   endfunction

   // Subtract over lo..hi by walking the open interval bounds up, then renormalize to the root.
   function automatic void span_take(int unsigned lo, int unsigned hi, longint amt);
      int unsigned s, t;
      s = lo + LEAVES - 1;
      t = hi + LEAVES + 1;
      while ((s ^ t ^ 1) != 0) begin
         if ((s & 1) == 0) cap_set(s ^ 1, cap_get(s ^ 1) - amt);
         if ((t & 1) != 0) cap_set(t ^ 1, cap_get(t ^ 1) - amt);
         pair_lift(s);
         pair_lift(t);
         s >>= 1;
         t >>= 1;
      end
      while (s > 1) begin
         pair_lift(s);
         s >>= 1;
      end
   endfunction

   function automatic int unsigned clamp_slot(logic [SLOT_W-1:0] v);
      if (v < 1) return 1;
      if (v > SLOT_TOP) return SLOT_TOP;
      return v;
   endfunction

   // Remaining capacity over a range as the block would see it, ends clamped and ordered.
   function automatic longint range_floor(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
      int unsigned lo, hi;
      lo = clamp_slot(a);
      hi = clamp_slot(b);
      if (lo > hi) return span_min(hi, lo);
      return span_min(lo, hi);
   endfunction

   // Apply one transfer to the predicted state and return the result it must produce.
   function automatic outcome_type reserve_outcome(logic cmd, logic [SLOT_W-1:0] first,
                                                   logic [SLOT_W-1:0] last,
                                                   logic [AMT_W-1:0] amt, logic last_load);
      outcome_type o;
      int unsigned lo, hi, tmp;
      longint m;
      o.minimum = '0;
      if (cmd == CMD_LOAD) begin
         if (first >= 1 && first <= SLOT_TOP) cap_set(first + LEAVES, longint'(amt));
         if (last_load) tree_build();
         o.status = STATUS_LOAD;
         o.number = request_count;
         return o;
      end
      if (request_count != COUNT_TOP) request_count++;
      o.number = request_count;
      if (refusing) begin
         o.status = STATUS_REFUSE;
         return o;
      end
      lo = clamp_slot(first);
      hi = clamp_slot(last);
      if (lo > hi) begin
         tmp = lo;
         lo = hi;
         hi = tmp;
      end
      m = span_min(lo, hi);
      o.minimum = m[AMT_W-1:0];
      if (m >= longint'(amt)) begin
         span_take(lo, hi, longint'(amt));
         o.status = STATUS_GRANT;
      end else begin
         refusing = 1'b1;
         o.status = STATUS_REJECT;
      end
      return o;
   endfunction

   // Send one item: optional idle cycles first, then hold start until the block takes it.
   // Start is only lowered inside the idle loop, so it never gets two updates in one step.
   task automatic send_item(logic cmd, logic [SLOT_W-1:0] first, logic [SLOT_W-1:0] last,
                            logic [AMT_W-1:0] amt, logic last_load);
      outcome_type want;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      want = reserve_outcome(cmd, first, last, amt, last_load);
      outcome_q = {outcome_q, want};
      start          <= 1'b1;
      req_command    <= cmd;
      req_first_slot <= first;
      req_last_slot  <= last;
      req_amount     <= amt;
      req_load_last  <= last_load;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [AMT_W-1:0] random_capacity();
      case ($urandom_range(3))
         0:       return AMT_W'($urandom);
         1:       return AMT_W'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
         default: return AMT_W'($urandom_range(32'h3FFF_FFFF, 32'h1000_0000));
      endcase
   endfunction

   // Reload a window of slots at a fresh base and rebuild. Every slot of the window is
   // reloaded so that its leaves hold absolute capacities when the build runs.
   task automatic reload_region();
      region_base = $urandom_range(SLOT_TOP - REGION + 1, 1);
      for (int k = 0; k < REGION; k++)
         send_item(CMD_LOAD, SLOT_W'(region_base + k), SLOT_W'($urandom), random_capacity(),
                   k == REGION - 1);
   endtask

   // Pick an amount that the predicted state will grant, mostly well below the floor.
   task automatic reserve_fit(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
      longint m;
      logic [AMT_W-1:0] amt;
      m = range_floor(a, b);
      if (m <= 0) amt = '0;
      else if (m > 64'h7FFF_FFFF) amt = AMT_W'($urandom_range(32'h7FFF_FFFF));
      else if ($urandom_range(9) == 0) amt = AMT_W'(m);
      else amt = AMT_W'($urandom_range(32'(m >> $urandom_range(12, 4))));
      send_item(CMD_RESERVE, a, b, amt, 1'(1 & $urandom));
   endtask

   // Reserves before any build see an all-zero tree, so only zero amounts fit.
   task automatic test_empty_tree();
      send_item(CMD_RESERVE, 10'd1, 10'd1022, '0, 1'b0);
      send_item(CMD_RESERVE, 10'd5, 10'd5, '0, 1'b1);
   endtask

   task automatic test_guard_loads();
      send_item(CMD_LOAD, 10'd0, 10'h3FF, 31'h7FFF_FFFF, 1'b0);
      send_item(CMD_LOAD, 10'd1023, 10'd0, 31'h5555_5555, 1'b0);
      send_item(CMD_LOAD, 10'd1022, 10'd0, 31'h7FFF_FFFF, 1'b0);
      send_item(CMD_LOAD, 10'd1, 10'd0, 31'h2AAA_AAAA, 1'b0);
      send_item(CMD_LOAD, 10'd0, 10'd0, 31'd0, 1'b1);
   endtask

   // Clamped and swapped ranges, single slots, zero amounts and exact fits.
   task automatic test_range_edges();
      send_item(CMD_RESERVE, 10'd0, 10'd1023, '0, 1'b0);
      send_item(CMD_RESERVE, 10'd1023, 10'd1022, '0, 1'b1);
      reload_region();
      reserve_fit(SLOT_W'(region_base + REGION - 1), SLOT_W'(region_base));
      send_item(CMD_RESERVE, SLOT_W'(region_base + 3), SLOT_W'(region_base + 3),
                AMT_W'(range_floor(SLOT_W'(region_base + 3), SLOT_W'(region_base + 3))), 1'b0);
      reserve_fit(SLOT_W'(region_base), SLOT_W'(region_base + REGION - 1));
      send_item(CMD_RESERVE, 10'd1022, 10'd1022,
                AMT_W'(range_floor(10'd1022, 10'd1022)), 1'b0);
      // Overwrite a leaf without a rebuild and reserve next to it, then rebuild.
      send_item(CMD_LOAD, SLOT_W'(region_base + 1), 10'd0, 31'd12345, 1'b0);
      reserve_fit(SLOT_W'(region_base + 4), SLOT_W'(region_base + 9));
      send_item(CMD_LOAD, SLOT_W'(region_base + 1), 10'd0, 31'h7FFF_FFFF, 1'b1);
   endtask

   // Mostly well-formed reserves inside the loaded window, with refills and stray ranges.
   task automatic test_random_traffic(int count);
      int lo, hi;
      for (int n = 0; n < count; n++) begin
         gap_pct = (n / 100) % 4 == 1 ? 70 : (n / 100) % 4 == 3 ? 38 : 0;
         case ($urandom_range(39))
            0:       reload_region();
            1:       send_item(CMD_LOAD, SLOT_W'(region_base + $urandom_range(REGION - 1)),
                               SLOT_W'($urandom), random_capacity(), 1'b0);
            2, 3, 4: reserve_fit(SLOT_W'($urandom), SLOT_W'($urandom));
            default: begin
               lo = region_base + $urandom_range(REGION - 1);
               hi = region_base + $urandom_range(REGION - 1);
               reserve_fit(SLOT_W'(lo), SLOT_W'(hi));
            end
         endcase
      end
      gap_pct = 0;
   endtask

   // First failure, then refused reserves and a load that still reports the count.
   task automatic test_rejection();
      longint m;
      m = range_floor(SLOT_W'(region_base), SLOT_W'(region_base + 2));
      send_item(CMD_RESERVE, SLOT_W'(region_base), SLOT_W'(region_base + 2),
                AMT_W'(m + 1), 1'b0);
      send_item(CMD_RESERVE, 10'd1, 10'd1, '0, 1'b0);
      send_item(CMD_RESERVE, 10'h3FF, 10'd0, 31'h7FFF_FFFF, 1'b1);
      send_item(CMD_LOAD, 10'd7, 10'd0, 31'd99, 1'b1);
      send_item(CMD_RESERVE, 10'h2AA, 10'h155, 31'h5555_5555, 1'b0);
   endtask

   // Every result is taken the cycle it is shown and matched against the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result status %0d number %0d minimum %0d", $time,
                     rsp_status, rsp_request_number, rsp_range_minimum);
            errors++;
         end else begin
            e = outcome_q.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_request_number !== e.number) begin
               $display("%0t: request_number expected %0d actual %0d", $time, e.number,
                        rsp_request_number);
               errors++;
            end
            if (rsp_range_minimum !== e.minimum) begin
               $display("%0t: range_minimum expected %0d actual %0d", $time, e.minimum,
                        rsp_range_minimum);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NODES; i++) cap_tree[i] = '0;
      request_count = '0;
      refusing = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_tree();
      test_guard_loads();
      test_range_edges();
      test_random_traffic(450);
      test_rejection();
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Timeout watchdog; it allows ample margin over the reserves and builds of the run.
   initial begin
      #60_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
